>>> rtl/core/assert_macros.svh
// Assertion macros for the event rate alarm RTL.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define WERA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define WERA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/wera_pkg.sv
// Shared widths, codes, stamp type and month table for the event rate alarm.
// No dependencies.
package wera_pkg;

  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int HOUR_W    = 5;
  localparam int MIN_W     = 6;
  localparam int SEC_W     = 6;
  localparam int TIME_W    = 25;
  localparam int THR_W     = 5;
  localparam int DOY_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int HOURS_PER_DAY = 24;
  localparam int SECS_PER_MIN  = 60;

  localparam logic [TIME_W-1:0] WINDOW_RST = 25'd60;
  localparam logic [THR_W-1:0]  THR_RST    = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW    = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
  } stamp_t;

  // cumulative leap-year day count at the start of each month
  function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd60;
      4'd4:    d = 9'd91;
      4'd5:    d = 9'd121;
      4'd6:    d = 9'd152;
      4'd7:    d = 9'd182;
      4'd8:    d = 9'd213;
      4'd9:    d = 9'd244;
      4'd10:   d = 9'd274;
      4'd11:   d = 9'd305;
      4'd12:   d = 9'd335;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

>>> rtl/core/wera_in_if.sv
// Event stamp input channel: valid/ready handshake with the stamp fields.
// Depends on wera_pkg.
interface wera_in_if import wera_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;

  modport source (output valid, month, day_of_month, hour, minute, second, input ready);
  modport sink   (input valid, month, day_of_month, hour, minute, second, output ready);
endinterface

>>> rtl/core/wera_out_if.sv
// Result channel: valid/ready handshake with event time and alarm flags.
// Depends on wera_pkg.
interface wera_out_if import wera_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] event_time;
  logic              alarm;
  logic              first_alarm;

  modport source (output valid, event_time, alarm, first_alarm, input ready);
  modport sink   (input valid, event_time, alarm, first_alarm, output ready);
endinterface

>>> rtl/core/wera_stamp_conv.sv
// Multi-cycle stamp to seconds converter: day of year, then hours, minutes, seconds.
// Depends on wera_pkg.
module wera_stamp_conv import wera_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  stamp_t            stamp,
  output logic              done,
  output logic [TIME_W-1:0] seconds
);

  logic [2:0]        step_r;
  logic [2:0]        step_nxt;
  logic              done_r;
  logic [TIME_W-1:0] acc_r;
  logic [TIME_W-1:0] acc_nxt;
  logic [HOUR_W-1:0] hour_r;
  logic [MIN_W-1:0]  min_r;
  logic [SEC_W-1:0]  sec_r;
  logic [TIME_W-1:0] mul;
  logic [TIME_W-1:0] add;

  always_comb begin
    mul      = step_r[0] ? TIME_W'(HOURS_PER_DAY) : TIME_W'(SECS_PER_MIN);
    add      = step_r[0] ? TIME_W'(hour_r) : (step_r[1] ? TIME_W'(min_r) : TIME_W'(sec_r));
    acc_nxt  = TIME_W'(acc_r * mul + add);
    step_nxt = start ? 3'b001 : {step_r[1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= step_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r  <= TIME_W'(month_start(stamp.month)) + TIME_W'(stamp.day_of_month);
      hour_r <= stamp.hour;
      min_r  <= stamp.minute;
      sec_r  <= stamp.second;
    end else if (|step_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done    = done_r;
  assign seconds = acc_r;

endmodule

>>> rtl/core/windowed_event_rate_alarm.sv
// Top level of the sliding-window event rate alarm: ring memory, scan sequencer, config.
// Depends on wera_pkg, wera_in_if, wera_out_if, wera_stamp_conv, assert_macros.svh.
//
//   channel  | dir | handshake       | payload
//   in_ch    | in  | valid / ready   | month, day_of_month, hour, minute, second
//   out_ch   | out | valid / ready   | event_time, alarm, first_alarm
//   cfg_*    | in  | cfg_we          | cfg_idx, cfg_wdata
//
// An item is accepted, its stamp converted, then the scan does one ring read per earlier
// stamp, need = min(threshold, MAX_THRESHOLD) - 1, drains and compares, and the item is
// written back. With nothing to compare (threshold of one or less, or too few stored
// stamps) the scan reads nothing and goes straight to write-back.
// Reset is synchronous; no clearing pass is needed.
// A held result stalls the write-back state; no new item is taken until it completes.
`include "assert_macros.svh"

module windowed_event_rate_alarm import wera_pkg::*; #(
  parameter int MAX_THRESHOLD = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [TIME_W-1:0]    cfg_wdata,
  wera_in_if.sink              in_ch,
  wera_out_if.source           out_ch
);

  localparam int AW = (MAX_THRESHOLD > 1) ? $clog2(MAX_THRESHOLD) : 1;
  localparam int FW = $clog2(MAX_THRESHOLD + 1);
  localparam int TW = (FW > THR_W) ? FW : THR_W;
  localparam int CW = TIME_W + 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_THRESHOLD - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [TIME_W-1:0] window_r;
  logic [THR_W-1:0]  thr_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              seen_r, seen_nxt;
  logic [TW-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              ok_r, ok_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [TIME_W-1:0] rd_data_r;
  logic [TIME_W-1:0] out_time_r;
  logic              out_alarm_r;
  logic              out_first_r;
  logic [TIME_W-1:0] ring_mem [MAX_THRESHOLD];

  stamp_t            in_stamp;
  logic              in_acc;
  logic              conv_done;
  logic [TIME_W-1:0] conv_secs;
  logic [TW-1:0]     thr_ext, max_ext, thr_sat, need;
  logic              need_ok;
  logic              out_free;
  logic              rd_en;
  logic              wr_en;
  logic              stamp_late;

  assign in_stamp = '{month: in_ch.month, day_of_month: in_ch.day_of_month,
                      hour: in_ch.hour, minute: in_ch.minute, second: in_ch.second};
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  wera_stamp_conv u_conv (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .stamp   (in_stamp),
    .done    (conv_done),
    .seconds (conv_secs)
  );

  assign thr_ext    = TW'(thr_r);
  assign max_ext    = TW'(MAX_THRESHOLD);
  assign thr_sat    = (thr_ext > max_ext) ? max_ext : thr_ext;
  assign need       = (thr_sat == '0) ? '0 : thr_sat - TW'(1);
  assign need_ok    = need <= TW'(fill_r);
  assign out_free   = !out_valid_r || out_ch.ready;
  assign stamp_late = (CW'(rd_data_r) + CW'(window_r)) <= CW'(conv_secs);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    seen_nxt      = seen_r;
    rd_cnt_nxt    = rd_cnt_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_vld_r;
    ok_nxt        = ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_CONV;
      end
      S_CONV: begin
        if (conv_done) begin
          state_nxt  = S_SCAN;
          rd_cnt_nxt = need_ok ? need : '0;
          ok_nxt     = need_ok;
          rd_idx_nxt = (head_r == '0) ? LAST_IDX : head_r - AW'(1);
          rd_vld_nxt = 1'b0;
        end
      end
      S_SCAN: begin
        rd_en = (rd_cnt_r != '0);
        if (rd_en) begin
          rd_idx_nxt = (rd_idx_r == '0) ? LAST_IDX : rd_idx_r - AW'(1);
          rd_cnt_nxt = rd_cnt_r - TW'(1);
        end
        rd_vld_nxt = rd_en;
        if (rd_vld_r && stamp_late) ok_nxt = 1'b0;
        if (!rd_en && !rd_vld_r) state_nxt = S_WR;
      end
      S_WR: begin
        if (out_free) begin
          wr_en         = 1'b1;
          head_nxt      = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
          fill_nxt      = (fill_r < FW'(MAX_THRESHOLD)) ? fill_r + FW'(1) : fill_r;
          seen_nxt      = seen_r || ok_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      window_r    <= WINDOW_RST;
      thr_r       <= THR_RST;
      head_r      <= '0;
      fill_r      <= '0;
      seen_r      <= 1'b0;
      rd_cnt_r    <= '0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      seen_r      <= seen_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      ok_r        <= ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          CFG_WINDOW:    window_r <= cfg_wdata;
          CFG_THRESHOLD: thr_r    <= cfg_wdata[THR_W-1:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[head_r] <= conv_secs;
    if (rd_en) rd_data_r <= ring_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_time_r  <= conv_secs;
      out_alarm_r <= ok_r;
      out_first_r <= ok_r && !seen_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_time  = out_time_r;
  assign out_ch.alarm       = out_alarm_r;
  assign out_ch.first_alarm = out_first_r;

  `WERA_ASSERT_IMPLY(a_first_alarm, out_valid_r && out_first_r, out_alarm_r, "lone first alarm")
  `WERA_ASSERT_IMPLY(a_fill_bound, 1'b1, fill_r <= FW'(MAX_THRESHOLD), "ring fill beyond depth")
  `WERA_ASSERT_NEXT(a_accept_to_conv, in_acc, state_r == S_CONV, "accepted item not converting")
  `WERA_ASSERT_NEXT(a_head_advances, wr_en, head_r != $past(head_r), "ring head stuck on write")

endmodule
